// ===== hdl/vl2n_pkg.sv =====
// Shared types, widths and controller codes for the vector L2 normalizer.
`default_nettype none

package vl2n_pkg;

	// Vector geometry
	localparam int VEC_LEN = 64;
	localparam int ADDR_W  = $clog2(VEC_LEN);
	localparam int CNT_W   = $clog2(VEC_LEN + 1);

	// Element and accumulator widths
	localparam int ELEM_W  = 16;
	localparam int SQ_W    = 31;
	localparam int SUM_W   = 37;

	// Square root unit: radicand is the sum shifted up by 26, root has 13 fraction bits
	localparam int RAD_SHIFT = 26;
	localparam int RAD_W     = 64;
	localparam int ROOT_W    = 32;
	localparam int SQR_REM_W = 34;

	// Divider: numerator is |x| * 2^29 + root, divisor is 2 * root
	localparam int NUM_SHIFT = 29;
	localparam int NUM_W     = 45;
	localparam int DEN_W     = ROOT_W + 1;
	localparam int QUO_W     = 17;
	localparam int DIV_REM_W = DEN_W;

	// Iteration counts (counter runs down to zero)
	localparam int ITER_W        = 5;
	localparam int ROOT_ITERS    = RAD_W / 2;
	localparam int DIV_ITERS     = QUO_W;

	// Saturation limits in magnitude form
	localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(32767);
	localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(32768);

	// Request and result payloads
	typedef struct packed {
		logic signed [ELEM_W-1:0] element;
		logic                     is_final;
	} in_req_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] norm_element;
		logic                     final_out;
		logic                     zero_norm;
		logic                     overflowed;
	} out_res_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_PREP,
		ST_ROOT,
		ST_RD,
		ST_LOAD,
		ST_DIV,
		ST_EMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic acc;
		logic prep;
		logic root_step;
		logic rd;
		logic div_load;
		logic div_step;
		logic emit;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic fin;
		logic sum_zero;
		logic zero_run;
		logic iter_last;
		logic last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/vl2n_ctrl.sv =====
// Sequencing state machine for the vector L2 normalizer.
`default_nettype none

module vl2n_ctrl
	import vl2n_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t stat
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = stat.fin ? ST_PREP : ST_IDLE;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = stat.sum_zero ? ST_RD : ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (stat.iter_last) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = stat.zero_run ? ST_EMIT : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.iter_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = stat.last ? ST_IDLE : ST_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/vl2n_dpath.sv =====
// Datapath: element buffer, square accumulator, bit-serial square root and divider.
`default_nettype none

module vl2n_dpath
	import vl2n_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire in_req_t req,
	input  wire dp_cmd_t cmd,
	output dp_stat_t     stat,
	output logic         done,
	output out_res_t     result
);

	// Element buffer
	logic [ELEM_W-1:0] mem [VEC_LEN];
	logic [ELEM_W-1:0] rd_data_q;

	// Run state
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic              drop_q;
	logic              fin_q;
	logic              zero_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ITER_W-1:0] iter_q;

	// Square pipeline stage
	logic signed [2*ELEM_W-1:0] sq_full;
	logic [SQ_W-1:0]            sq_s1;
	logic                       room;

	// Square root unit
	logic [RAD_W-1:0]     rad_q;
	logic [SQR_REM_W-1:0] srem_q;
	logic [ROOT_W-1:0]    root_q;
	logic [SQR_REM_W+1:0] s_cand;
	logic [SQR_REM_W+1:0] s_trial;
	logic                 s_take;

	// Divider
	logic [DIV_REM_W-1:0] drem_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 sign_q;
	logic [ELEM_W-1:0]    mag;
	logic [NUM_W-1:0]     num;
	logic [DEN_W-1:0]     den;
	logic [DIV_REM_W:0]   d_cand;
	logic                 d_take;

	// Output
	logic [ELEM_W-1:0] res_val;
	logic              last;
	logic              done_q;
	out_res_t          result_q;

	assign room    = count_q < CNT_W'(VEC_LEN);
	assign sq_full = req.element * req.element;
	assign last    = (CNT_W'({1'b0, idx_q}) + CNT_W'(1)) == count_q;

	// Buffer write on accept, registered read
	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			mem[count_q[ADDR_W-1:0]] <= req.element;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[idx_q];
		end
	end

	// Square stage: dropped elements contribute nothing
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sq_s1 <= room ? sq_full[SQ_W-1:0] : '0;
		end
	end

	// Run bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			drop_q  <= 1'b0;
			fin_q   <= 1'b0;
			zero_q  <= 1'b0;
			idx_q   <= '0;
			iter_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.load) begin
				fin_q <= req.is_final;
				if (room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.acc) begin
				sum_q <= sum_q + SUM_W'(sq_s1);
			end
			if (cmd.prep) begin
				zero_q <= (sum_q == '0);
				idx_q  <= '0;
				iter_q <= ITER_W'(ROOT_ITERS - 1);
			end
			if (cmd.div_load) begin
				iter_q <= ITER_W'(DIV_ITERS - 1);
			end
			if (cmd.root_step || cmd.div_step) begin
				iter_q <= iter_q - ITER_W'(1);
			end
			if (cmd.emit) begin
				if (last) begin
					count_q <= '0;
					sum_q   <= '0;
					drop_q  <= 1'b0;
				end else begin
					idx_q <= idx_q + ADDR_W'(1);
				end
			end
		end
	end

	// Square root: two radicand bits per step, one root bit out
	assign s_cand  = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign s_trial = {2'b00, root_q, 2'b01};
	assign s_take  = s_cand >= s_trial;

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rad_q  <= RAD_W'({sum_q, {RAD_SHIFT{1'b0}}});
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			srem_q <= s_take ? SQR_REM_W'(s_cand - s_trial) : s_cand[SQR_REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], s_take};
		end
	end

	// Divider: restoring, one quotient bit per step
	assign mag    = rd_data_q[ELEM_W-1] ? ELEM_W'(~rd_data_q + ELEM_W'(1)) : rd_data_q;
	assign num    = ({mag, {NUM_SHIFT{1'b0}}}) + NUM_W'(root_q);
	assign den    = {root_q, 1'b0};
	assign d_cand = {drem_q, quo_q[QUO_W-1]};
	assign d_take = d_cand >= {1'b0, den};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			sign_q <= rd_data_q[ELEM_W-1];
			drem_q <= DIV_REM_W'(num[NUM_W-1:QUO_W]);
			quo_q  <= num[QUO_W-1:0];
		end else if (cmd.div_step) begin
			drem_q <= d_take ? DIV_REM_W'(d_cand - {1'b0, den}) : d_cand[DIV_REM_W-1:0];
			quo_q  <= {quo_q[QUO_W-2:0], d_take};
		end
	end

	// Sign and saturation
	always_comb begin
		res_val = '0;
		if (!zero_q) begin
			if (sign_q) begin
				res_val = (quo_q > NEG_LIMIT) ? NEG_LIMIT[ELEM_W-1:0]
				                              : ELEM_W'(QUO_W'(0) - quo_q);
				if (quo_q > NEG_LIMIT) begin
					res_val = ELEM_W'(QUO_W'(0) - NEG_LIMIT);
				end
			end else begin
				res_val = (quo_q > POS_LIMIT) ? POS_LIMIT[ELEM_W-1:0] : quo_q[ELEM_W-1:0];
			end
		end
	end

	// Result register, one-cycle strobe
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.norm_element <= res_val;
			result_q.final_out    <= last;
			result_q.zero_norm    <= zero_q;
			result_q.overflowed   <= drop_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Status to controller
	always_comb begin
		stat           = '0;
		stat.fin       = fin_q;
		stat.sum_zero  = (sum_q == '0);
		stat.zero_run  = zero_q;
		stat.iter_last = (iter_q == '0);
		stat.last      = last;
	end

	// Buffer never holds more than the vector length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(VEC_LEN))
		else $error("element count past vector length");

	// A nonzero sum needs at least one stored element
	a_sum_count: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_q != '0) |-> (count_q != '0))
		else $error("square sum without stored elements");

	// Normalized magnitude never exceeds one
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !zero_q) |-> (quo_q <= NEG_LIMIT))
		else $error("divider quotient above unit magnitude");

	// Strobe only follows an emit command
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.emit))
		else $error("result strobe without emit");

	// Run state is cleared after the final result
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && last) |=> (count_q == '0 && !drop_q))
		else $error("run state not cleared after final result");

endmodule

`default_nettype wire

// ===== hdl/vector_l2_normalizer_core.sv =====
// Top level of the vector L2 normalizer: controller plus datapath.
//
//  channel  | ports               | handshake
//  ---------+---------------------+------------------------------------------
//  request  | req (in_req_t)      | taken at a clock edge with start=1, busy=0
//  result   | result (out_res_t)  | valid for one cycle while done=1
//
// A non-final element is accepted, then the square of it is accumulated.
// The final element adds a prepare step and the bit-serial square root,
// then for each stored element a buffer read, a divider load, the 17-step
// restoring divider and an emit. A zero-norm vector skips root and divider.
// Results leave one per done pulse and cannot be stalled.
// Reset clears the run count, sum and flags; the buffer needs no clearing.
`default_nettype none

module vector_l2_normalizer_core
	import vl2n_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire in_req_t req,
	output logic         done,
	output out_res_t     result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer
	vl2n_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	// Datapath
	vl2n_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire
